FILE: rtl/lph_pkg.sv
// lph_pkg: shared types, codes and constants of the linear probing hash table
// used by lph_dp, lph_ctrl, linear_probe_hash_table_core and the testbench; no dependencies
package lph_pkg;

	// default geometry
	localparam int SLOTS_DEF     = 16;
	localparam int KEY_BYTES_DEF = 8;

	// fixed field widths
	localparam int OPCODE_W = 2;
	localparam int KEY_IN_W = 64;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [OPCODE_W-1:0] {
		OP_FIND   = 2'd0,
		OP_ADD    = 2'd1,
		OP_GET    = 2'd2,
		OP_REMOVE = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HWAIT,
		S_LRD,
		S_LCK,
		S_RMRD,
		S_RMCK,
		S_RIRD,
		S_RILD,
		S_RIHASH,
		S_RIHWAIT,
		S_RIPRD,
		S_RIPCK,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    clr_step;
		logic    load_in;
		logic    hash_start;
		logic    ptr_home;
		logic    mem_rd;
		logic    probe_next;
		logic    cnt_one;
		logic    wr_cur;
		logic    wr_zero;
		logic    held_push;
		logic    held_rd;
		logic    cur_from_held;
		logic    ri_next;
		logic    res_load;
		logic    res_found;
		logic    res_take_val;
		status_t res_status;
		logic    out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    key_zero;
		logic    rd_empty;
		logic    rd_match;
		logic    last_probe;
		logic    clr_last;
		logic    hcnt_zero;
		logic    ri_last;
		logic    mod_busy;
		logic    out_free;
	} sts_t;

endpackage

FILE: rtl/linear_probe_hash_table_core.sv
// linear_probe_hash_table_core: open-addressing key/value table with linear probing
// reset starts a clearing pass over every slot of the store; no item is taken meanwhile
// one item at a time: the home slot is computed from the key, then each slot on the probe
// path is read and then checked; a zero key gives its result without probing; the next
// item is taken once the result is in the output register; remove also lifts the rest of
// the cluster and reinserts each entry from its home slot; depends on lph_pkg, lph_ctrl, lph_dp and lph_mod
module linear_probe_hash_table_core #(
	parameter int SLOTS     = lph_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = lph_pkg::KEY_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// opcode[1:0], key[65:2], write_value[97:66], zero pad above
	input  logic [lph_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// found[0], read_value[32:1], status[34:33], zero pad above
	output logic [lph_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	import lph_pkg::*;

	cmd_t               cmd;
	sts_t               sts;
	logic               out_found;
	logic [VALUE_W-1:0] out_read_value;
	status_t            out_status;

	// controller
	lph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	lph_dp #(
		.SLOTS     (SLOTS),
		.KEY_BYTES (KEY_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_opcode      (opcode_t'(s_axis_tdata[1:0])),
		.in_key         (s_axis_tdata[65:2]),
		.in_value       (s_axis_tdata[97:66]),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_found      (out_found),
		.out_read_value (out_read_value),
		.out_status     (out_status)
	);

	// result packing
	assign m_axis_tdata = {5'b0, out_status, out_read_value, out_found};

`ifndef SYNTHESIS
	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while previous item in progress");

	// remainder unit runs after a start
	a_mod_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hash_start |=> sts.mod_busy)
		else $error("home slot unit did not start");

	// a waiting result is never overwritten
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten before taken");

	// store writes come from one source at a time
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.wr_cur, cmd.wr_zero}))
		else $error("conflicting store writes");
`endif

endmodule

FILE: rtl/lph_mod.sv
// lph_mod: remainder by a constant divisor through a scaled reciprocal multiply
// computes the home slot from the key byte sum; no package dependencies
module lph_mod #(
	parameter int SUM_W   = 11,
	parameter int DIVISOR = 16,
	parameter int REM_W   = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	output logic             busy,
	output logic [REM_W-1:0] rem
);

	// reciprocal scaled by 2**SHIFT, exact for every dividend below 2**SUM_W
	localparam int     DIV_LW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
	localparam int     SHIFT  = SUM_W + DIV_LW;
	localparam int     MUL_W  = SUM_W + 2;
	localparam int     PROD_W = SUM_W + MUL_W;
	localparam int     QD_W   = SUM_W + DIV_LW + 1;
	localparam longint MUL_V  =
		((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
	localparam logic [MUL_W-1:0] MUL_C = MUL_W'(MUL_V);
	localparam logic [QD_W-1:0]  DIV_C = QD_W'(DIVISOR);

	logic              busy_q;
	logic              phase_q;
	logic [SUM_W-1:0]  div_q;
	logic [SUM_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod;
	logic [QD_W-1:0]   quo_x_div;
	logic [SUM_W-1:0]  diff;

	// quotient estimate: dividend times scaled reciprocal
	assign prod = PROD_W'(div_q) * PROD_W'(MUL_C);

	// remainder: dividend minus quotient times divisor
	assign quo_x_div = QD_W'(quo_q) * DIV_C;
	assign diff      = div_q - quo_x_div[SUM_W-1:0];

	// step control: quotient cycle, then remainder cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (busy_q) begin
			if (phase_q) begin
				busy_q  <= 1'b0;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	// dividend, quotient and remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
		end else if (busy_q && !phase_q) begin
			quo_q <= SUM_W'(prod >> SHIFT);
		end else if (busy_q && phase_q) begin
			rem_q <= REM_W'(diff);
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/lph_dp.sv
// lph_dp: datapath with slot store, cluster hold buffer, probe pointers and result register
// depends on lph_pkg and lph_mod
module lph_dp #(
	parameter int SLOTS     = lph_pkg::SLOTS_DEF,
	parameter int KEY_BYTES = lph_pkg::KEY_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lph_pkg::opcode_t                in_opcode,
	input  logic [lph_pkg::KEY_IN_W-1:0]    in_key,
	input  logic [lph_pkg::VALUE_W-1:0]     in_value,
	input  lph_pkg::cmd_t                   cmd,
	output lph_pkg::sts_t                   sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_found,
	output logic [lph_pkg::VALUE_W-1:0]     out_read_value,
	output lph_pkg::status_t                out_status
);

	import lph_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int ENT_W = KEY_W + VALUE_W;
	localparam int SUM_W = $clog2(KEY_BYTES * 255 + 1);

	// slot store and cluster hold buffer
	logic [ENT_W-1:0] mem  [SLOTS];
	logic [ENT_W-1:0] held [SLOTS];

	opcode_t          op_q;
	logic [KEY_W-1:0] key_q;
	logic [VALUE_W-1:0] val_q;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] hcnt_q;
	logic [IDX_W-1:0] ri_q;
	logic [ENT_W-1:0] rd_q;
	logic [ENT_W-1:0] hrd_q;

	logic               res_found_q;
	logic [VALUE_W-1:0] res_rv_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [VALUE_W-1:0] out_rv_q;
	status_t            out_status_q;

	logic [SUM_W-1:0]   byte_sum;
	logic [IDX_W-1:0]   home;
	logic               mod_busy;
	logic [IDX_W-1:0]   ptr_nxt;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENT_W-1:0]   wr_data;
	logic [KEY_W-1:0]   rd_key;
	logic [VALUE_W-1:0] rd_val;

	// byte sum of the current key
	always_comb begin
		byte_sum = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			byte_sum = byte_sum + SUM_W'(key_q[8*i +: 8]);
		end
	end

	// home slot = byte sum modulo slot count
	lph_mod #(
		.SUM_W   (SUM_W),
		.DIVISOR (SLOTS),
		.REM_W   (IDX_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.hash_start),
		.dividend (byte_sum),
		.busy     (mod_busy),
		.rem      (home)
	);

	// wrapping probe step
	assign ptr_nxt = (ptr_q == IDX_W'(SLOTS - 1)) ? '0 : ptr_q + 1'b1;

	// store write port select
	always_comb begin
		wr_en   = cmd.clr_step | cmd.wr_cur | cmd.wr_zero;
		wr_addr = cmd.clr_step ? clr_q : ptr_q;
		wr_data = cmd.wr_cur ? {val_q, key_q} : '0;
	end

	// slot store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[ptr_q];
		end
	end

	// cluster hold buffer, registered read
	always_ff @(posedge clk) begin
		if (cmd.held_push) begin
			held[hcnt_q] <= rd_q;
		end
		if (cmd.held_rd) begin
			hrd_q <= held[ri_q];
		end
	end

	assign rd_key = rd_q[KEY_W-1:0];
	assign rd_val = rd_q[ENT_W-1:KEY_W];

	// current item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= in_opcode;
			key_q <= in_key[KEY_W-1:0];
			val_q <= in_value;
		end else if (cmd.cur_from_held) begin
			key_q <= hrd_q[KEY_W-1:0];
			val_q <= hrd_q[ENT_W-1:KEY_W];
		end
	end

	// probe pointer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			cnt_q  <= '0;
			clr_q  <= '0;
			hcnt_q <= '0;
			ri_q   <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.ptr_home) begin
				ptr_q <= home;
				cnt_q <= '0;
			end else if (cmd.probe_next) begin
				ptr_q <= ptr_nxt;
				cnt_q <= cmd.cnt_one ? IDX_W'(1) : cnt_q + 1'b1;
			end
			if (cmd.load_in) begin
				hcnt_q <= '0;
				ri_q   <= '0;
			end else begin
				if (cmd.held_push) begin
					hcnt_q <= hcnt_q + 1'b1;
				end
				if (cmd.ri_next) begin
					ri_q <= ri_q + 1'b1;
				end
			end
		end
	end

	// result of the current item
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_found_q  <= cmd.res_found;
			res_status_q <= cmd.res_status;
			if (cmd.res_take_val) begin
				res_rv_q <= rd_val;
			end else begin
				res_rv_q <= (op_q == OP_GET) ? '1 : '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_found_q  <= res_found_q;
			out_rv_q     <= res_rv_q;
			out_status_q <= res_status_q;
		end
	end

	// status to controller
	always_comb begin
		sts.op         = op_q;
		sts.key_zero   = (key_q == '0);
		sts.rd_empty   = (rd_key == '0);
		sts.rd_match   = (rd_key == key_q);
		sts.last_probe = (cnt_q == IDX_W'(SLOTS - 1));
		sts.clr_last   = (clr_q == IDX_W'(SLOTS - 1));
		sts.hcnt_zero  = (hcnt_q == '0);
		sts.ri_last    = (ri_q == hcnt_q - 1'b1);
		sts.mod_busy   = mod_busy;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign out_found      = out_found_q;
	assign out_read_value = out_rv_q;
	assign out_status     = out_status_q;

endmodule

FILE: rtl/lph_ctrl.sv
// lph_ctrl: controller state machine sequencing clear, lookup, remove and reinsertion
// depends on lph_pkg
module lph_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lph_pkg::sts_t sts,
	output lph_pkg::cmd_t cmd
);

	import lph_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = S_HASH;
			end
			S_HASH: begin
				state_nxt = sts.key_zero ? S_DONE : S_HWAIT;
			end
			S_HWAIT: begin
				if (!sts.mod_busy) state_nxt = S_LRD;
			end
			S_LRD: state_nxt = S_LCK;
			S_LCK: begin
				if (sts.rd_empty) begin
					state_nxt = S_DONE;
				end else if (sts.rd_match) begin
					state_nxt = (sts.op == OP_REMOVE) ? S_RMRD : S_DONE;
				end else if (sts.last_probe) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_LRD;
				end
			end
			S_RMRD: state_nxt = S_RMCK;
			S_RMCK: begin
				if (sts.rd_empty) begin
					state_nxt = sts.hcnt_zero ? S_DONE : S_RIRD;
				end else if (sts.last_probe) begin
					state_nxt = S_RIRD;
				end else begin
					state_nxt = S_RMRD;
				end
			end
			S_RIRD:   state_nxt = S_RILD;
			S_RILD:   state_nxt = S_RIHASH;
			S_RIHASH: state_nxt = S_RIHWAIT;
			S_RIHWAIT: begin
				if (!sts.mod_busy) state_nxt = S_RIPRD;
			end
			S_RIPRD: state_nxt = S_RIPCK;
			S_RIPCK: begin
				if (sts.rd_empty || sts.last_probe) begin
					state_nxt = sts.ri_last ? S_DONE : S_RIRD;
				end else begin
					state_nxt = S_RIPRD;
				end
			end
			S_DONE: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd            = '0;
		cmd.res_status = ST_NOT_FOUND;
		in_ready       = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_HASH: begin
				if (sts.key_zero) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
				end else begin
					cmd.hash_start = 1'b1;
				end
			end
			S_HWAIT: cmd.ptr_home = !sts.mod_busy;
			S_LRD:   cmd.mem_rd = 1'b1;
			S_LCK: begin
				if (sts.rd_empty) begin
					// miss at an empty slot: add claims it
					cmd.res_load = 1'b1;
					if (sts.op == OP_ADD) begin
						cmd.wr_cur     = 1'b1;
						cmd.res_status = ST_OK;
					end else begin
						cmd.res_status = ST_NOT_FOUND;
					end
				end else if (sts.rd_match) begin
					cmd.res_load   = 1'b1;
					cmd.res_found  = 1'b1;
					cmd.res_status = ST_OK;
					case (sts.op)
						OP_ADD:    cmd.wr_cur = 1'b1;
						OP_GET:    cmd.res_take_val = 1'b1;
						OP_REMOVE: begin
							cmd.wr_zero    = 1'b1;
							cmd.probe_next = 1'b1;
							cmd.cnt_one    = 1'b1;
						end
						default: ;
					endcase
				end else if (sts.last_probe) begin
					// one full round without match or empty slot
					cmd.res_load   = 1'b1;
					cmd.res_status = (sts.op == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			S_RMRD: cmd.mem_rd = 1'b1;
			S_RMCK: begin
				// pull the rest of the cluster into the hold buffer
				if (!sts.rd_empty) begin
					cmd.held_push  = 1'b1;
					cmd.wr_zero    = 1'b1;
					cmd.probe_next = !sts.last_probe;
				end
			end
			S_RIRD:   cmd.held_rd = 1'b1;
			S_RILD:   cmd.cur_from_held = 1'b1;
			S_RIHASH: cmd.hash_start = 1'b1;
			S_RIHWAIT: cmd.ptr_home = !sts.mod_busy;
			S_RIPRD:  cmd.mem_rd = 1'b1;
			S_RIPCK: begin
				if (sts.rd_empty || sts.last_probe) begin
					cmd.wr_cur  = sts.rd_empty;
					cmd.ri_next = !sts.ri_last;
				end else begin
					cmd.probe_next = 1'b1;
				end
			end
			S_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

FILE: tb/sv/tb_linear_probe_hash_table_core.sv
// tb_linear_probe_hash_table_core: self-checking stream testbench for the linear probing table,
// with a scoreboard class that keeps its own copy of the slot store and predicts every result
// depends on lph_pkg and linear_probe_hash_table_core
`timescale 1ns / 1ps

typedef struct packed {
	logic                found;
	logic [31:0]         read_value;
	lph_pkg::status_t    status;
} table_result_t;

// scoreboard: shadow slot store, expected results in order of acceptance
class lph_scoreboard;
	localparam int SLOTS     = lph_pkg::SLOTS_DEF;
	localparam int KEY_BYTES = lph_pkg::KEY_BYTES_DEF;

	logic [63:0]   slot_key [SLOTS];
	logic [31:0]   slot_val [SLOTS];
	table_result_t pending_results [$];
	int            mismatches;

	function new();
		for (int i = 0; i < SLOTS; i++) begin
			slot_key[i] = '0;
			slot_val[i] = '0;
		end
		mismatches = 0;
	endfunction

	function logic [63:0] mask_key(logic [63:0] k);
		return k & ({64{1'b1}} >> (64 - 8 * KEY_BYTES));
	endfunction

	// byte sum of the key modulo the slot count
	function int home_of(logic [63:0] k);
		int unsigned sum;
		sum = 0;
		for (int i = 0; i < KEY_BYTES; i++)
			sum += 32'(k[8*i +: 8]);
		return sum % SLOTS;
	endfunction

	// slot holding k, or -1; gives up after one round
	function int locate(logic [63:0] k);
		int s;
		s = home_of(k);
		for (int n = 0; n < SLOTS; n++) begin
			if (slot_key[s] == '0)
				return -1;
			if (slot_key[s] == k)
				return s;
			s = (s + 1) % SLOTS;
		end
		return -1;
	endfunction

	function bit holds(logic [63:0] k);
		logic [63:0] m;
		m = mask_key(k);
		return (m != '0) && (locate(m) >= 0);
	endfunction

	// first empty slot on the probe path
	function bit place(logic [63:0] k, logic [31:0] v);
		int s;
		s = home_of(k);
		for (int n = 0; n < SLOTS; n++) begin
			if (slot_key[s] == '0) begin
				slot_key[s] = k;
				slot_val[s] = v;
				return 1'b1;
			end
			s = (s + 1) % SLOTS;
		end
		return 1'b0;
	endfunction

	// clear a slot, lift the rest of its cluster and put it back from home
	function void take_out(int pos);
		logic [63:0] held_key [$];
		logic [31:0] held_val [$];
		int          s;
		s = pos;
		slot_key[pos] = '0;
		slot_val[pos] = '0;
		for (int n = 1; n < SLOTS; n++) begin
			s = (s + 1) % SLOTS;
			if (slot_key[s] == '0)
				break;
			held_key.push_back(slot_key[s]);
			held_val.push_back(slot_val[s]);
			slot_key[s] = '0;
			slot_val[s] = '0;
		end
		foreach (held_key[i])
			void'(place(held_key[i], held_val[i]));
	endfunction

	// apply one accepted item to the shadow store and queue its result
	function void note_input(lph_pkg::opcode_t op, logic [63:0] key, logic [31:0] wv);
		table_result_t r;
		logic [63:0]   k;
		int            pos;
		k = mask_key(key);
		r.found      = 1'b0;
		r.status     = lph_pkg::ST_NOT_FOUND;
		r.read_value = (op == lph_pkg::OP_GET) ? 32'hFFFF_FFFF : 32'h0;
		pos = (k == '0) ? -1 : locate(k);
		if (pos >= 0) begin
			r.found  = 1'b1;
			r.status = lph_pkg::ST_OK;
			case (op)
				lph_pkg::OP_ADD:    slot_val[pos] = wv;
				lph_pkg::OP_GET:    r.read_value = slot_val[pos];
				lph_pkg::OP_REMOVE: take_out(pos);
				default: ;
			endcase
		end else if (op == lph_pkg::OP_ADD && k != '0) begin
			r.status = place(k, wv) ? lph_pkg::ST_OK : lph_pkg::ST_FULL;
		end
		pending_results.push_back(r);
	endfunction

	// compare one result item with the oldest expectation
	function void check_result(logic [lph_pkg::OUT_TDATA_W-1:0] data);
		table_result_t want, got;
		got.found      = data[0];
		got.read_value = data[32:1];
		got.status     = lph_pkg::status_t'(data[34:33]);
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result item with none expected: found %0b read_value %h status %0d",
					$realtime, got.found, got.read_value, got.status);
			return;
		end
		want = pending_results.pop_front();
		if (got != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch found %0b/%0b read_value %h/%h status %0d/%0d (exp/act)",
					$realtime, want.found, got.found, want.read_value, got.read_value,
					want.status, got.status);
		end
	endfunction
endclass

module tb_linear_probe_hash_table_core;
	import lph_pkg::*;

	localparam int POOL      = 20;
	localparam int RAND_ITEMS = 550;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// opcode[1:0], key[65:2], write_value[97:66], zero pad above
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// found[0], read_value[32:1], status[34:33], zero pad above
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	lph_scoreboard sb;
	int            tx_idle = 27;
	int            rx_idle = 70;
	logic [63:0]   key_pool [POOL];

	linear_probe_hash_table_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#100_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receive side: check accepted result items, random back-pressure
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			m_axis_tready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	// short key of random length with random bytes, never zero
	function automatic logic [63:0] short_key();
		logic [63:0] k;
		int          n;
		k = '0;
		n = $urandom_range(1, KEY_BYTES_DEF);
		for (int i = 0; i < n; i++)
			k[8*i +: 8] = 8'($urandom_range(0, 255));
		if (k == '0)
			k[7:0] = 8'h01;
		return k;
	endfunction

	function automatic logic [63:0] wide_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		if (k == '0)
			k[0] = 1'b1;
		return k;
	endfunction

	// one input item, with random gaps before it
	task automatic send_item(input opcode_t op, input logic [63:0] key, input logic [31:0] wv);
		while ($urandom_range(0, 99) < tx_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - 98){1'b0}}, wv, key, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(op, key, wv);
	endtask

	// random item; fill mode leans on add, drain mode on remove
	task automatic random_item(input bit fill);
		int          pick;
		int          idx;
		opcode_t     op;
		logic [63:0] k;
		pick = $urandom_range(0, 99);
		if (fill) begin
			if (pick < 55)      op = OP_ADD;
			else if (pick < 75) op = OP_GET;
			else if (pick < 85) op = OP_FIND;
			else                op = OP_REMOVE;
		end else begin
			if (pick < 15)      op = OP_ADD;
			else if (pick < 35) op = OP_GET;
			else if (pick < 45) op = OP_FIND;
			else                op = OP_REMOVE;
		end
		idx = $urandom_range(0, POOL - 1);
		// swap in a fresh wide key only when the old one is not stored
		if (op == OP_ADD && $urandom_range(0, 9) == 0 && !sb.holds(key_pool[idx]))
			key_pool[idx] = wide_key();
		pick = $urandom_range(0, 99);
		if (pick < 3)
			k = '0;
		else if (pick < 13 && op != OP_ADD)
			k = wide_key();
		else
			k = key_pool[idx];
		send_item(op, k, $urandom);
	endtask

	// stimulus
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		sb = new();
		for (int i = 0; i < POOL; i++)
			key_pool[i] = short_key();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// zero key is absent for every operation
		send_item(OP_FIND,   64'h0, 32'h0);
		send_item(OP_ADD,    64'h0, 32'h5);
		send_item(OP_GET,    64'h0, 32'h0);
		send_item(OP_REMOVE, 64'h0, 32'h0);
		// misses on the empty store
		send_item(OP_GET,    64'h01, 32'h0);
		send_item(OP_REMOVE, 64'h01, 32'h0);
		// field extremes
		send_item(OP_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
		send_item(OP_ADD,    64'h01, 32'h7FFF_FFFF);
		// cluster at home slot 1, pushed into slot 2's key
		send_item(OP_ADD,    64'h11, 32'h0);
		send_item(OP_ADD,    64'h21, 32'hFFFF_FFFF);
		send_item(OP_ADD,    64'h02, 32'h0000_1234);
		send_item(OP_GET,    64'h21, 32'h0);
		send_item(OP_ADD,    64'h11, 32'hDEAD_BEEF);
		send_item(OP_FIND,   64'h02, 32'h0);
		// remove the head of the cluster, the rest moves back
		send_item(OP_REMOVE, 64'h01, 32'h0);
		send_item(OP_GET,    64'h02, 32'h0);
		send_item(OP_GET,    64'h11, 32'h0);
		send_item(OP_FIND,   64'h01, 32'h0);
		send_item(OP_GET,    64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_item(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		// cluster wrapping from the last slot to the first
		send_item(OP_FIND,   64'h0F, 32'h0);
		send_item(OP_ADD,    64'h0F, 32'h7);
		send_item(OP_ADD,    64'h1F, 32'h8);
		send_item(OP_REMOVE, 64'h0F, 32'h0);
		send_item(OP_GET,    64'h1F, 32'h0);

		// random part over three idle settings
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle = 27; rx_idle = 70; end
				1: begin tx_idle = 70; rx_idle = 27; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			for (int n = 0; n < RAND_ITEMS; n++)
				random_item(((n / 60) % 2) == 0);
		end
		s_axis_tvalid <= 1'b0;

		// drain, then watch for stray result items
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
rtl/lph_pkg.sv
rtl/lph_mod.sv
rtl/lph_dp.sv
rtl/lph_ctrl.sv
rtl/linear_probe_hash_table_core.sv
tb/sv/tb_linear_probe_hash_table_core.sv
